// ===== hw/rtl/kpm_pkg.sv =====
// Shared constants and controller/datapath interface types for the k-partition core.
`default_nettype none
package kpm_pkg;

    localparam int MAX_ITEMS   = 256;
    localparam int WEIGHT_BITS = 8;
    localparam int CFG_W       = 9;
    localparam int IDX_W       = $clog2(MAX_ITEMS + 1);
    localparam int LIDX_W      = $clog2(MAX_ITEMS);
    localparam int PAIR_SLOTS  = (MAX_ITEMS * (MAX_ITEMS - 1)) / 2;
    localparam int SLOT_W      = $clog2(PAIR_SLOTS);
    localparam int POS_W       = 16;
    localparam int CADDR_W     = 2 * LIDX_W;
    localparam int RADDR_W     = IDX_W + 1;
    localparam int COL_W       = 16;
    localparam int COST_W      = 24;
    localparam int DP_W        = 25;
    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Configuration register indexes.
    localparam logic CFG_ITEM_COUNT  = 1'b0;
    localparam logic CFG_GROUP_COUNT = 1'b1;

    // Input item kinds.
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_COMPUTE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                load_we;
        logic [SLOT_W-1:0]   load_addr;
        logic                build_init;
        logic                col_start;
        logic                build_acc;
        logic                dp_acc;
        logic                row_we;
        logic                out_load;
        logic                out_inf;
        logic                first;
        logic                zero_c;
        logic                prev_zero;
        logic [IDX_W-1:0]    n;
        logic [IDX_W-1:0]    r_idx;
        logic [IDX_W-1:0]    l_idx;
        logic [CADDR_W-1:0]  c_raddr;
        logic [CADDR_W-1:0]  c_waddr;
        logic [RADDR_W-1:0]  row_raddr;
        logic [RADDR_W-1:0]  row_waddr;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/kpm_dp.sv =====
// Datapath: weight, span cost and DP row memories, adders, result register.
`default_nettype none
module kpm_dp (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire kpm_pkg::t_cmd           i_cmd,
    output kpm_pkg::t_sts                o_sts,
    input  wire [kpm_pkg::WEIGHT_BITS-1:0] i_load_data,
    input  wire                          i_out_ready,
    output logic                         o_out_valid,
    output logic [kpm_pkg::COST_W-1:0]   o_min_cost,
    output logic                         o_infeasible
);
    import kpm_pkg::*;

    logic [WEIGHT_BITS-1:0] w_mem   [PAIR_SLOTS];
    logic [COST_W-1:0]      c_mem   [2**CADDR_W];
    logic [DP_W-1:0]        row_mem [2**RADDR_W];

    logic [WEIGHT_BITS-1:0] r_w_q;
    logic [COST_W-1:0]      r_c_q;
    logic [DP_W-1:0]        r_row_q;
    logic [SLOT_W:0]        r_base, n_base;
    logic [SLOT_W:0]        r_slot, n_slot;
    logic [COL_W-1:0]       r_colsum;
    logic [DP_W-1:0]        r_best;
    logic                   r_out_valid;
    logic [COST_W-1:0]      r_out_cost;
    logic                   r_out_inf;

    logic [COL_W-1:0]       colsum_n;
    logic [COST_W-1:0]      span_cost;
    logic [DP_W-1:0]        cand;
    logic [COST_W-1:0]      sat_cost;

    // Weight store: written by loads, read at the running slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_we) begin
            w_mem[i_cmd.load_addr] <= i_load_data;
        end
        r_w_q <= w_mem[r_slot[SLOT_W-1:0]];
    end

    // Span cost store.
    always_ff @(posedge i_clk) begin
        if (i_cmd.build_acc) begin
            c_mem[i_cmd.c_waddr] <= span_cost;
        end
        r_c_q <= c_mem[i_cmd.c_raddr];
    end

    // Two DP rows, selected by the low bit of the group index.
    always_ff @(posedge i_clk) begin
        if (i_cmd.row_we) begin
            row_mem[i_cmd.row_waddr] <= r_best;
        end
        r_row_q <= row_mem[i_cmd.row_raddr];
    end

    // Column running sum and span cost for the build pass.
    assign colsum_n  = (i_cmd.first ? '0 : r_colsum) + COL_W'(r_w_q);
    assign span_cost = (i_cmd.zero_c ? '0 : r_c_q) + COST_W'(colsum_n);

    // Candidate cost for one split point.
    assign cand = (i_cmd.prev_zero ? '0 : r_row_q) +
                  (i_cmd.zero_c ? '0 : DP_W'(r_c_q));

    // Slot of pair (l, r) walks down a column without a multiplier.
    always_comb begin
        n_base = r_base;
        n_slot = r_slot;
        if (i_cmd.build_init) begin
            n_base = '0;
        end else if (i_cmd.col_start) begin
            n_slot = r_base;
            n_base = r_base + (SLOT_W+1)'(i_cmd.n - i_cmd.r_idx);
        end else if (i_cmd.build_acc) begin
            n_slot = r_slot - (SLOT_W+1)'(i_cmd.n - i_cmd.l_idx - IDX_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        r_base <= n_base;
        r_slot <= n_slot;
        if (i_cmd.build_acc) begin
            r_colsum <= colsum_n;
        end
        if (i_cmd.dp_acc && (i_cmd.first || cand < r_best)) begin
            r_best <= cand;
        end
    end

    // Result register.
    assign sat_cost = (r_row_q > DP_W'(COST_MAX)) ? COST_MAX : r_row_q[COST_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_cost <= i_cmd.out_inf ? '0 : sat_cost;
            r_out_inf  <= i_cmd.out_inf;
        end
    end

    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_min_cost     = r_out_cost;
    assign o_infeasible   = r_out_inf;

endmodule
`default_nettype wire

// ===== hw/rtl/kpm_ctrl.sv =====
// Controller: configuration registers, load position and the sequencing state machine.
`default_nettype none
module kpm_ctrl (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_cfg_valid,
    input  wire                        i_cfg_index,
    input  wire [kpm_pkg::CFG_W-1:0]   i_cfg_data,
    input  wire                        i_in_valid,
    output logic                       o_in_ready,
    input  wire                        i_action,
    input  wire kpm_pkg::t_sts         i_sts,
    output kpm_pkg::t_cmd              o_cmd
);
    import kpm_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_BCOL = 4'd1;
    localparam logic [3:0] S_BRD  = 4'd2;
    localparam logic [3:0] S_BACC = 4'd3;
    localparam logic [3:0] S_DE   = 4'd4;
    localparam logic [3:0] S_DRD  = 4'd5;
    localparam logic [3:0] S_DACC = 4'd6;
    localparam logic [3:0] S_DWR  = 4'd7;
    localparam logic [3:0] S_FRD  = 4'd8;
    localparam logic [3:0] S_FWT  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    logic [3:0]       r_state, n_state;
    logic [CFG_W-1:0] r_item_count, r_group_count;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [IDX_W-1:0] r_r, n_r, r_l, n_l, r_k, n_k, r_e, n_e, r_m, n_m;
    logic             r_inf, n_inf;

    logic [IDX_W-1:0] act_n;
    logic [IDX_W-1:0] grp;
    logic [2*IDX_W-1:0] n_prod;
    logic [POS_W-1:0] expected;
    logic             infeasible;
    logic             accept;
    logic [IDX_W-1:0] e_m1, r_m1;
    logic             last_m;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item_count  <= CFG_W'(1);
            r_group_count <= CFG_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ITEM_COUNT:  r_item_count  <= i_cfg_data;
                CFG_GROUP_COUNT: r_group_count <= i_cfg_data;
                default:         r_item_count  <= r_item_count;
            endcase
        end
    end

    // Item count clamped to the supported range.
    always_comb begin
        if (r_item_count == '0) begin
            act_n = IDX_W'(1);
        end else if (r_item_count > CFG_W'(MAX_ITEMS)) begin
            act_n = IDX_W'(MAX_ITEMS);
        end else begin
            act_n = r_item_count[IDX_W-1:0];
        end
    end

    assign grp        = r_group_count[IDX_W-1:0];
    assign n_prod     = act_n * (act_n - IDX_W'(1));
    assign expected   = POS_W'(n_prod >> 1);
    assign infeasible = (r_group_count == '0) || (r_group_count > CFG_W'(act_n));
    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign e_m1       = r_e - IDX_W'(1);
    assign r_m1       = r_r - IDX_W'(1);
    assign last_m     = (r_k == IDX_W'(1)) ? (r_m == '0) : (r_m == e_m1);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_r     = r_r;
        n_l     = r_l;
        n_k     = r_k;
        n_e     = r_e;
        n_m     = r_m;
        n_inf   = r_inf;
        o_cmd   = '0;
        o_cmd.n         = act_n;
        o_cmd.r_idx     = r_r;
        o_cmd.l_idx     = r_l;
        o_cmd.load_addr = r_pos[SLOT_W-1:0];
        o_cmd.c_raddr   = {r_l[LIDX_W-1:0], r_m1[LIDX_W-1:0]};
        o_cmd.c_waddr   = {r_l[LIDX_W-1:0], r_r[LIDX_W-1:0]};
        o_cmd.row_raddr = {grp[0], act_n};
        o_cmd.row_waddr = {r_k[0], r_e};
        o_cmd.out_inf   = r_inf;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_action == ACT_LOAD) begin
                        if (r_pos < expected) begin
                            o_cmd.load_we = 1'b1;
                            n_pos = r_pos + POS_W'(1);
                        end
                    end else begin
                        n_pos = '0;
                        o_cmd.build_init = 1'b1;
                        n_r = IDX_W'(1);
                        n_k = IDX_W'(1);
                        n_e = IDX_W'(1);
                        n_inf = infeasible;
                        if (infeasible) begin
                            n_state = S_OUT;
                        end else if (act_n == IDX_W'(1)) begin
                            n_state = S_DE;
                        end else begin
                            n_state = S_BCOL;
                        end
                    end
                end
            end
            // Build span costs column by column, l walking down from r-1.
            S_BCOL: begin
                o_cmd.col_start = 1'b1;
                n_l = r_m1;
                n_state = S_BRD;
            end
            S_BRD: begin
                n_state = S_BACC;
            end
            S_BACC: begin
                o_cmd.build_acc = 1'b1;
                o_cmd.first  = (r_l == r_m1);
                o_cmd.zero_c = (r_l == r_m1);
                if (r_l == '0) begin
                    if (r_r == act_n - IDX_W'(1)) begin
                        n_state = S_DE;
                    end else begin
                        n_r = r_r + IDX_W'(1);
                        n_state = S_BCOL;
                    end
                end else begin
                    n_l = r_l - IDX_W'(1);
                    n_state = S_BRD;
                end
            end
            // Partition rows: best over split points m for each end e.
            S_DE: begin
                n_m = r_k - IDX_W'(1);
                n_state = S_DRD;
            end
            S_DRD: begin
                o_cmd.row_raddr = {~r_k[0], r_m};
                o_cmd.c_raddr   = {r_m[LIDX_W-1:0], e_m1[LIDX_W-1:0]};
                n_state = S_DACC;
            end
            S_DACC: begin
                o_cmd.dp_acc    = 1'b1;
                o_cmd.first     = (r_m == r_k - IDX_W'(1));
                o_cmd.zero_c    = (r_m == e_m1);
                o_cmd.prev_zero = (r_k == IDX_W'(1));
                if (last_m) begin
                    n_state = S_DWR;
                end else begin
                    n_m = r_m + IDX_W'(1);
                    n_state = S_DRD;
                end
            end
            S_DWR: begin
                o_cmd.row_we = 1'b1;
                if (r_e == act_n) begin
                    if (r_k == grp) begin
                        n_state = S_FRD;
                    end else begin
                        n_k = r_k + IDX_W'(1);
                        n_e = r_k + IDX_W'(1);
                        n_state = S_DE;
                    end
                end else begin
                    n_e = r_e + IDX_W'(1);
                    n_state = S_DE;
                end
            end
            S_FRD: begin
                n_state = S_FWT;
            end
            S_FWT: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos   <= '0;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r   <= n_r;
        r_l   <= n_l;
        r_k   <= n_k;
        r_e   <= n_e;
        r_m   <= n_m;
        r_inf <= n_inf;
    end

endmodule
`default_nettype wire

// ===== hw/rtl/contiguous_k_partition_min_cost_core.sv =====
// A load is absorbed in its transfer cycle. A compute builds span costs column by column,
// then works through each DP entry over its split points (one split
// point in the first row, e-k+1 in row k), then reads out into the result register once
// it is free. An infeasible request skips both passes and goes straight to the result stage.
// Throughput: one load per cycle; a compute closes the input until its result is loaded.
// Reset (synchronous, active low) clears state, load position, result valid; counts go to 1.
`default_nettype none
module contiguous_k_partition_min_cost_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_valid,
    output logic       o_cfg_ready,
    input  wire        i_cfg_index,
    input  wire [8:0]  i_cfg_data,
    input  wire        s_axis_tvalid,
    output logic       s_axis_tready,
    input  wire [7:0]  s_axis_tdata,   // [7:0] pair_weight
    input  wire        s_axis_tuser,   // [0] action
    output logic       m_axis_tvalid,
    input  wire        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // [23:0] min_cost
    output logic       m_axis_tuser    // [0] infeasible
);
    import kpm_pkg::*;

    t_cmd cmd;
    t_sts sts;

    assign o_cfg_ready = 1'b1;

    // Sequencer.
    kpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_action    (s_axis_tuser),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Storage and arithmetic.
    kpm_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_load_data  (s_axis_tdata),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_min_cost   (m_axis_tdata),
        .o_infeasible (m_axis_tuser)
    );

`ifndef ASSERT_OFF
    // A result never overwrites one that has not been transferred.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> sts.out_free)
        else $error("result loaded over a pending result");

    // Weight writes only happen on an input transfer of a load.
    a_load_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_we |-> (s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_LOAD)))
        else $error("weight write without a load transfer");

    // The input side is closed while a result is being produced.
    a_busy_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.build_acc || cmd.dp_acc || cmd.row_we) |-> !s_axis_tready)
        else $error("input open during computation");
`endif

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the contiguous k-partition minimum-cost core.
`default_nettype none
module tb_top;
    import kpm_pkg::*;

    localparam int LIMIT_CYCLES = 50000000;
    localparam int SETTLE       = 40;
    localparam int ITEM_TARGET  = 1800;

    typedef struct packed {
        logic [COST_W-1:0] cost;
        logic              inf;
    } t_answer;

    typedef enum logic [1:0] {ROW_CFG, ROW_ITEM, ROW_END} t_row_kind;

    typedef struct {
        t_row_kind kind;
        logic      index;
        int        value;
        logic      act;
        int        weight;
        bit        typed;
        t_answer   answer;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic        i_cfg_index;
    logic [8:0]  i_cfg_data;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] pair_weight
    logic        s_axis_tuser;   // [0] action
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // [23:0] min_cost
    logic        m_axis_tuser;   // [0] infeasible

    contiguous_k_partition_min_cost_core i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Mirror of the block state.
    logic [WEIGHT_BITS-1:0] weights [PAIR_SLOTS];
    int unsigned            load_pos;
    int unsigned            written_mark;
    int unsigned            items_reg;
    int unsigned            groups_reg;
    longint                 span_cost [MAX_ITEMS][MAX_ITEMS];
    longint                 dp_prev [MAX_ITEMS+1];
    longint                 dp_cur [MAX_ITEMS+1];
    bit                     ok_prev [MAX_ITEMS+1];
    bit                     ok_cur [MAX_ITEMS+1];

    t_answer     pending_answers [$];
    int          errors;
    int          cycles;
    int          sent_items;
    int          computes_seen;
    int          infeasible_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_request;
    int          hold_left;

    // Clock.
    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic int unsigned active_items();
        if (items_reg == 0) return 1;
        if (items_reg > MAX_ITEMS) return MAX_ITEMS;
        return items_reg;
    endfunction

    function automatic int unsigned slot_of(int unsigned n, int unsigned i, int unsigned j);
        return i * n - (i * (i + 1)) / 2 + (j - i - 1);
    endfunction

    // Store one weight if the current matrix still has room for it.
    function automatic void predict_load(logic [7:0] w);
        int unsigned n;
        n = active_items();
        if (load_pos < n * (n - 1) / 2 && load_pos < PAIR_SLOTS) begin
            weights[load_pos] = w[WEIGHT_BITS-1:0];
            load_pos = load_pos + 1;
            if (load_pos > written_mark) written_mark = load_pos;
        end
    endfunction

    // Span costs by column sums, then the rolling-row partition recurrence.
    function automatic t_answer predict_partition();
        t_answer     ans;
        int unsigned n;
        int unsigned g;
        longint      colsum;
        longint      c;
        longint      best;
        bit          found;
        n = active_items();
        g = groups_reg;
        ans.cost = '0;
        ans.inf  = 1'b1;
        load_pos = 0;
        if (g == 0 || g > n || g > MAX_ITEMS) return ans;
        for (int l = 0; l < n; l++) span_cost[l][l] = 0;
        for (int r = 1; r < n; r++) begin
            colsum = 0;
            for (int l = r - 1; l >= 0; l--) begin
                colsum += weights[slot_of(n, l, r)];
                span_cost[l][r] = span_cost[l][r-1] + colsum;
            end
        end
        for (int e = 0; e <= n; e++) begin
            ok_prev[e] = 0;
            dp_prev[e] = 0;
        end
        ok_prev[0] = 1;
        for (int k = 1; k <= g; k++) begin
            for (int e = 0; e <= n; e++) begin
                found = 0;
                best  = 0;
                if (e >= k) begin
                    for (int m = k - 1; m < e; m++) begin
                        if (ok_prev[m]) begin
                            c = dp_prev[m] + span_cost[m][e-1];
                            if (!found || c < best) begin
                                best  = c;
                                found = 1;
                            end
                        end
                    end
                end
                ok_cur[e] = found;
                dp_cur[e] = best;
            end
            dp_prev = dp_cur;
            ok_prev = ok_cur;
        end
        if (ok_prev[n]) begin
            ans.cost = (dp_prev[n] > longint'(COST_MAX)) ? COST_MAX : dp_prev[n][COST_W-1:0];
            ans.inf  = 1'b0;
        end
        return ans;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
    endtask

    // Cycle limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Result side back-pressure, with an optional long hold-off.
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left     = hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Result checker: sample between edges, judge the transfer at the edge.
    initial begin : result_check
        bit          took;
        logic [23:0] got_cost;
        logic        got_inf;
        t_answer     want;
        forever begin
            @(negedge i_clk);
            took     = i_rst_n && m_axis_tvalid && m_axis_tready;
            got_cost = m_axis_tdata;
            got_inf  = m_axis_tuser;
            @(posedge i_clk);
            if (took) begin
                if (pending_answers.size() == 0) begin
                    report_mismatch("unexpected result, cost", got_cost, -1);
                end else begin
                    want = pending_answers.pop_front();
                    if (got_cost !== want.cost) report_mismatch("min_cost", got_cost, want.cost);
                    if (got_inf !== want.inf) report_mismatch("infeasible", got_inf, want.inf);
                end
            end
        end
    end

    task automatic write_register(logic index, int value);
        bit rdy;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value[8:0];
        do begin
            @(negedge i_clk);
            rdy = o_cfg_ready;
            @(posedge i_clk);
        end while (!rdy);
        i_cfg_valid <= 1'b0;
        if (index == CFG_ITEM_COUNT) items_reg = value & 9'h1FF;
        else groups_reg = value & 9'h1FF;
    endtask

    // Offer one item; for a compute, an answer is queued when the transfer completes.
    task automatic send_item(logic act, int w, bit typed, t_answer typed_ans);
        bit      rdy;
        int      gap;
        t_answer ans;
        gap = 0;
        if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(6, 1);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= w[7:0];
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        sent_items++;
        if (act == ACT_COMPUTE) begin
            ans = predict_partition();
            computes_seen++;
            if (ans.inf) infeasible_seen++;
            pending_answers.push_back(typed ? typed_ans : ans);
        end else begin
            predict_load(w[7:0]);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One matrix with random content, then a compute.
    task automatic run_matrix();
        int unsigned n;
        int unsigned need;
        int unsigned loads;
        int          w;
        t_answer     none;
        none = '0;
        n    = active_items();
        need = n * (n - 1) / 2;
        loads = need;
        // Occasionally short or long on loads; short only where old weights cover it.
        if ($urandom_range(9) == 0 && written_mark >= need && need > 0)
            loads = $urandom_range(need - 1);
        else if ($urandom_range(7) == 0)
            loads = need + $urandom_range(3, 1);
        for (int i = 0; i < loads; i++) begin
            case ($urandom_range(3))
                0: w = 0;
                1: w = 255;
                default: w = $urandom_range(255);
            endcase
            send_item(ACT_LOAD, w, 0, none);
        end
        send_item(ACT_COMPUTE, $urandom_range(255), 0, none);
    endtask

    task automatic random_settings();
        int unsigned n;
        int unsigned g;
        n = ($urandom_range(15) == 0) ? $urandom_range(24, 13) : $urandom_range(12, 2);
        case ($urandom_range(5))
            0: g = 0;
            1: g = 1;
            2: g = n;
            3: g = n + 1;
            default: g = $urandom_range(n, 1);
        endcase
        write_register(CFG_ITEM_COUNT, n);
        write_register(CFG_GROUP_COUNT, g);
    endtask

    t_row directed [$];

    function automatic t_row mk_cfg(logic index, int value);
        t_row r;
        r = '{ROW_CFG, index, value, 1'b0, 0, 0, '0};
        return r;
    endfunction

    function automatic t_row mk_item(logic act, int w);
        t_row r;
        r = '{ROW_ITEM, 1'b0, 0, act, w, 0, '0};
        return r;
    endfunction

    function automatic t_row mk_known(int cost, logic inf);
        t_row r;
        r = '{ROW_ITEM, 1'b0, 0, ACT_COMPUTE, 0, 1, '{cost[COST_W-1:0], inf}};
        return r;
    endfunction

    initial begin : stimulus
        int      phase_idle [4];
        int      phase_stall [4];
        int      per_phase;
        bit      held_once;
        held_once      = 1'b0;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_ITEM_COUNT;
        i_cfg_data     = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = ACT_LOAD;
        m_axis_tready  = 1'b0;
        errors         = 0;
        cycles         = 0;
        sent_items     = 0;
        computes_seen  = 0;
        infeasible_seen = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 0;
        hold_left      = 0;
        load_pos       = 0;
        written_mark   = 0;
        items_reg      = 1;
        groups_reg     = 1;
        foreach (weights[i]) weights[i] = '0;

        // Directed table: reset state, range edges, ignored loads, infeasible requests.
        directed = '{
            mk_known(0, 1'b0),
            mk_cfg(CFG_GROUP_COUNT, 0),   mk_known(0, 1'b1),
            mk_cfg(CFG_ITEM_COUNT, 2),    mk_cfg(CFG_GROUP_COUNT, 1),
            mk_item(ACT_LOAD, 255),       mk_item(ACT_LOAD, 7),
            mk_known(255, 1'b0),
            mk_cfg(CFG_ITEM_COUNT, 3),    mk_cfg(CFG_GROUP_COUNT, 2),
            mk_item(ACT_LOAD, 255),       mk_item(ACT_LOAD, 0),
            mk_item(ACT_LOAD, 255),       mk_item(ACT_LOAD, 128),
            mk_item(ACT_COMPUTE, 0),
            mk_cfg(CFG_GROUP_COUNT, 3),   mk_known(0, 1'b0),
            mk_cfg(CFG_GROUP_COUNT, 4),   mk_known(0, 1'b1),
            mk_cfg(CFG_ITEM_COUNT, 0),    mk_cfg(CFG_GROUP_COUNT, 1),
            mk_known(0, 1'b0),
            mk_cfg(CFG_ITEM_COUNT, 511),  mk_cfg(CFG_GROUP_COUNT, 511),
            mk_known(0, 1'b1),
            mk_cfg(CFG_GROUP_COUNT, 257), mk_known(0, 1'b1),
            mk_cfg(CFG_ITEM_COUNT, 4),    mk_cfg(CFG_GROUP_COUNT, 2),
            mk_item(ACT_LOAD, 1),         mk_item(ACT_LOAD, 2),
            mk_item(ACT_LOAD, 4),         mk_item(ACT_LOAD, 8),
            mk_item(ACT_LOAD, 16),        mk_item(ACT_LOAD, 32),
            mk_item(ACT_COMPUTE, 255),
            '{ROW_END, 1'b0, 0, 1'b0, 0, 0, '0}
        };

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed[i]) begin
            case (directed[i].kind)
                ROW_CFG: begin
                    drain_results();
                    write_register(directed[i].index, directed[i].value);
                end
                ROW_ITEM: send_item(directed[i].act, directed[i].weight,
                                    directed[i].typed, directed[i].answer);
                default: drain_results();
            endcase
        end

        // Random part in four pacing phases.
        phase_idle  = '{0, 73, 0, 22};
        phase_stall = '{0, 0, 73, 22};
        per_phase   = ITEM_TARGET / 4;
        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = phase_idle[p];
            recv_stall_pct = phase_stall[p];
            while (sent_items < per_phase * (p + 1)) begin
                drain_results();
                random_settings();
                for (int k = $urandom_range(3, 1); k > 0; k--) run_matrix();
                // Long hold-off on the result side while computes keep coming.
                if (p == 1 && (!held_once || $urandom_range(5) == 0)) begin
                    held_once    = 1'b1;
                    hold_request = 600;
                    for (int k = 0; k < 3; k++) run_matrix();
                end
                // Sometimes the sender waits for everything to come back before going on.
                if ($urandom_range(4) == 0) drain_results();
            end
        end

        drain_results();
        $display("Covered %0d transfers in, %0d computes (%0d infeasible), in %0d cycles.",
                 sent_items, computes_seen, infeasible_seen, cycles);
        $display("Included range edges of both registers and long result hold-offs.");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
`default_nettype wire
